FILE: src/cau_pkg.sv
// ============================================================================
// cau_pkg
// Shared types, widths and helpers for the complex arithmetic unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    // Operand format and derived widths
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = PROD_W + 1;
    localparam int MAG_W      = PROD_W + FRAC_BITS;
    localparam int REM_W      = 3 * DATA_WIDTH + FRAC_BITS;
    localparam int NUM_CELLS  = DATA_WIDTH;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SAT      = 2'd1,
        ST_DIV_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        op_t                          operation;
        logic signed [DATA_WIDTH-1:0] a_real;
        logic signed [DATA_WIDTH-1:0] a_imag;
        logic signed [DATA_WIDTH-1:0] b_real;
        logic signed [DATA_WIDTH-1:0] b_imag;
    } in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_real;
        logic signed [DATA_WIDTH-1:0] result_imag;
        status_t                      status;
    } out_t;

    // One lane of the divide chain: partial remainder, shifted divisor, quotient
    typedef struct packed {
        logic [REM_W-1:0]      rem;
        logic [REM_W-1:0]      dsh;
        logic [DATA_WIDTH-1:0] quot;
        logic                  neg;
        logic                  ovf;
    } lane_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  flag;
    } sat_t;

    // Clamp a sign-magnitude value to the signed word range
    function automatic sat_t saturate(logic neg, logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] limit;
        logic [MAG_W-1:0] m;
        sat_t             r;
        limit = neg ? (MAG_W'(1) << (DATA_WIDTH - 1))
                    : ((MAG_W'(1) << (DATA_WIDTH - 1)) - MAG_W'(1));
        m      = mag;
        r.flag = 1'b0;
        if (m > limit)
        begin
            m      = limit;
            r.flag = 1'b1;
        end
        r.value = neg ? DATA_WIDTH'(MAG_W'(0) - m) : DATA_WIDTH'(m);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/complex_arithmetic_unit.sv
// ============================================================================
// complex_arithmetic_unit
// Pipelined complex ALU: add, subtract, multiply, divide on signed Q8.8.
// ============================================================================
// Takes one item every clock cycle; busy is always low. Every operation
// passes through the same registers: a product register, a sum register,
// a setup register, one register per quotient bit in the chain of divide
// cells, and the result register. A result is shown on result for one
// cycle with result_valid high and must be taken then: the receiver cannot
// stall, and results leave in issue order.
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire cau_pkg::in_t operands,
    output logic             result_valid,
    output cau_pkg::out_t    result
);
    import cau_pkg::*;

    localparam int LATENCY = NUM_CELLS + 4;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ---------------- stage A: products and part sums ----------------
    logic                         va_reg;
    op_t                          op_a_reg;
    logic signed [PROD_W-1:0]     p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic signed [PROD_W-1:0]     p_br_reg, p_bi_reg;
    logic signed [DATA_WIDTH:0]   as_re_reg, as_im_reg;
    logic signed [DATA_WIDTH:0]   as_re_next, as_im_next;

    always_comb
    begin
        if (operands.operation == OP_SUB)
        begin
            as_re_next = (DATA_WIDTH+1)'(operands.a_real) - (DATA_WIDTH+1)'(operands.b_real);
            as_im_next = (DATA_WIDTH+1)'(operands.a_imag) - (DATA_WIDTH+1)'(operands.b_imag);
        end
        else
        begin
            as_re_next = (DATA_WIDTH+1)'(operands.a_real) + (DATA_WIDTH+1)'(operands.b_real);
            as_im_next = (DATA_WIDTH+1)'(operands.a_imag) + (DATA_WIDTH+1)'(operands.b_imag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        op_a_reg  <= operands.operation;
        p_rr_reg  <= PROD_W'(operands.a_real) * PROD_W'(operands.b_real);
        p_ii_reg  <= PROD_W'(operands.a_imag) * PROD_W'(operands.b_imag);
        p_ir_reg  <= PROD_W'(operands.a_imag) * PROD_W'(operands.b_real);
        p_ri_reg  <= PROD_W'(operands.a_real) * PROD_W'(operands.b_imag);
        p_br_reg  <= PROD_W'(operands.b_real) * PROD_W'(operands.b_real);
        p_bi_reg  <= PROD_W'(operands.b_imag) * PROD_W'(operands.b_imag);
        as_re_reg <= as_re_next;
        as_im_reg <= as_im_next;
    end

    // ---------------- stage B: sums of products ----------------
    logic                       vb_reg;
    op_t                        op_b_reg;
    logic signed [SUM_W-1:0]    m_re_reg, m_im_reg, d_re_reg, d_im_reg;
    logic [PROD_W-1:0]          den_reg;
    logic signed [DATA_WIDTH:0] as_re_b_reg, as_im_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        op_b_reg    <= op_a_reg;
        m_re_reg    <= SUM_W'(p_rr_reg) - SUM_W'(p_ii_reg);
        m_im_reg    <= SUM_W'(p_ir_reg) + SUM_W'(p_ri_reg);
        d_re_reg    <= SUM_W'(p_rr_reg) + SUM_W'(p_ii_reg);
        d_im_reg    <= SUM_W'(p_ir_reg) - SUM_W'(p_ri_reg);
        den_reg     <= p_br_reg + p_bi_reg;
        as_re_b_reg <= as_re_reg;
        as_im_b_reg <= as_im_reg;
    end

    // ---------------- stage C: finish add/sub/mul, set up divide ----------------
    logic [SUM_W-1:0]      m_re_mag, m_im_mag, d_re_mag, d_im_mag;
    logic [SUM_W-1:0]      m_re_sh, m_im_sh;
    logic [DATA_WIDTH:0]   as_re_mag, as_im_mag;
    sat_t                  sat_re, sat_im;
    logic                  dz_next;
    out_t                  side_next;
    lane_t                 lane_re_next, lane_im_next;
    logic [REM_W-1:0]      den_w;

    always_comb
    begin
        m_re_mag  = m_re_reg[SUM_W-1] ? SUM_W'(-m_re_reg) : SUM_W'(m_re_reg);
        m_im_mag  = m_im_reg[SUM_W-1] ? SUM_W'(-m_im_reg) : SUM_W'(m_im_reg);
        d_re_mag  = d_re_reg[SUM_W-1] ? SUM_W'(-d_re_reg) : SUM_W'(d_re_reg);
        d_im_mag  = d_im_reg[SUM_W-1] ? SUM_W'(-d_im_reg) : SUM_W'(d_im_reg);
        as_re_mag = as_re_b_reg[DATA_WIDTH] ? (DATA_WIDTH+1)'(-as_re_b_reg)
                                            : (DATA_WIDTH+1)'(as_re_b_reg);
        as_im_mag = as_im_b_reg[DATA_WIDTH] ? (DATA_WIDTH+1)'(-as_im_b_reg)
                                            : (DATA_WIDTH+1)'(as_im_b_reg);
        m_re_sh   = m_re_mag >> FRAC_BITS;
        m_im_sh   = m_im_mag >> FRAC_BITS;

        if (op_b_reg == OP_MUL)
        begin
            sat_re = saturate(m_re_reg[SUM_W-1], MAG_W'(m_re_sh));
            sat_im = saturate(m_im_reg[SUM_W-1], MAG_W'(m_im_sh));
        end
        else
        begin
            sat_re = saturate(as_re_b_reg[DATA_WIDTH], MAG_W'(as_re_mag));
            sat_im = saturate(as_im_b_reg[DATA_WIDTH], MAG_W'(as_im_mag));
        end

        dz_next               = (den_reg == '0);
        side_next.result_real = sat_re.value;
        side_next.result_imag = sat_im.value;
        side_next.status      = (sat_re.flag || sat_im.flag) ? ST_SAT : ST_OK;
        if (dz_next && (op_b_reg == OP_DIV))
        begin
            side_next.result_real = '0;
            side_next.result_imag = '0;
            side_next.status      = ST_DIV_ZERO;
        end

        // Scaled numerator and divisor aligned for the first quotient bit
        den_w             = REM_W'(den_reg);
        lane_re_next.rem  = REM_W'(d_re_mag) << FRAC_BITS;
        lane_re_next.dsh  = den_w << (DATA_WIDTH - 1);
        lane_re_next.quot = '0;
        lane_re_next.neg  = d_re_reg[SUM_W-1];
        lane_re_next.ovf  = (lane_re_next.rem >= (den_w << DATA_WIDTH));
        lane_im_next.rem  = REM_W'(d_im_mag) << FRAC_BITS;
        lane_im_next.dsh  = den_w << (DATA_WIDTH - 1);
        lane_im_next.quot = '0;
        lane_im_next.neg  = d_im_reg[SUM_W-1];
        lane_im_next.ovf  = (lane_im_next.rem >= (den_w << DATA_WIDTH));
    end

    // ---------------- divide chain with side pipeline ----------------
    logic                vld_reg  [NUM_CELLS+1];
    logic                div_reg  [NUM_CELLS+1];
    out_t                side_reg [NUM_CELLS+1];
    lane_t               re_chain [NUM_CELLS+1];
    lane_t               im_chain [NUM_CELLS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        div_reg[0]  <= (op_b_reg == OP_DIV) && !dz_next;
        side_reg[0] <= side_next;
        re_chain[0] <= lane_re_next;
        im_chain[0] <= lane_im_next;
    end

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        cau_div_cell u_re (
            .clk      (clk),
            .lane_in  (re_chain[k]),
            .lane_out (re_chain[k+1])
        );
        cau_div_cell u_im (
            .clk      (clk),
            .lane_in  (im_chain[k]),
            .lane_out (im_chain[k+1])
        );

        // Hold the non-divide result alongside the cell
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            div_reg[k+1]  <= div_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    // ---------------- stage D: select and saturate quotient ----------------
    lane_t qre, qim;
    sat_t  q_re_sat, q_im_sat;
    out_t  result_next;
    logic  result_valid_reg;
    out_t  result_reg;

    always_comb
    begin
        qre      = re_chain[NUM_CELLS];
        qim      = im_chain[NUM_CELLS];
        q_re_sat = saturate(qre.neg, qre.ovf ? (MAG_W'(1) << DATA_WIDTH)
                                             : MAG_W'(qre.quot));
        q_im_sat = saturate(qim.neg, qim.ovf ? (MAG_W'(1) << DATA_WIDTH)
                                             : MAG_W'(qim.quot));
        result_next = side_reg[NUM_CELLS];
        if (div_reg[NUM_CELLS])
        begin
            result_next.result_real = q_re_sat.value;
            result_next.result_imag = q_im_sat.value;
            result_next.status      = (q_re_sat.flag || q_im_sat.flag) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= vld_reg[NUM_CELLS];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- assertions ----------------
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY result_valid)
        else $error("transfer did not complete at the fixed latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, LATENCY))
        else $error("result without a matching input transfer");

    a_div_zero_parts: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_DIV_ZERO)
            |-> (result.result_real == '0 && result.result_imag == '0))
        else $error("divide by zero gave non-zero parts");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == ST_OK || result.status == ST_SAT
                          || result.status == ST_DIV_ZERO))
        else $error("unused status code delivered");

endmodule

`default_nettype wire

FILE: src/cau_div_cell.sv
// ============================================================================
// cau_div_cell
// One restoring-division step: compare, subtract, shift in one quotient bit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cau_div_cell (
    input  wire logic          clk,
    input  wire cau_pkg::lane_t lane_in,
    output cau_pkg::lane_t      lane_out
);
    import cau_pkg::*;

    lane_t lane_reg;
    lane_t lane_next;
    logic  ge;

    // Take one quotient bit and halve the divisor for the next cell
    always_comb
    begin
        ge             = (lane_in.rem >= lane_in.dsh);
        lane_next      = lane_in;
        lane_next.rem  = ge ? (lane_in.rem - lane_in.dsh) : lane_in.rem;
        lane_next.dsh  = lane_in.dsh >> 1;
        lane_next.quot = {lane_in.quot[DATA_WIDTH-2:0], ge};
    end

    // Advance the lane to the neighbour
    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ============================================================================
// tb
// Self-checking bench for the complex arithmetic unit: directed corner
// operands, then random traffic under varying start gaps, scored in order.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import cau_pkg::*;

    localparam int LATENCY   = DATA_WIDTH + 4;
    localparam int N_RANDOM  = 1550;
    localparam int MAX_CYCLE = 200000;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    in_t   operands;
    logic  result_valid;
    out_t  result;

    int    n_errors;
    int    n_sent;
    int    cycle;
    int    idle_pct;
    int    op_count [4];

    complex_arithmetic_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operands     (operands),
        .result_valid (result_valid),
        .result       (result)
    );

    // Report one mismatch and count it
    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle, what);
        n_errors++;
    endtask

    // Sign-magnitude helpers for exact wide arithmetic
    typedef struct {
        bit            neg;
        bit [63:0]     mag;
    } smag_t;

    function automatic smag_t to_smag(longint x);
        smag_t r;
        r.neg = x < 0;
        r.mag = r.neg ? -x : x;
        return r;
    endfunction

    function automatic smag_t add_smag(smag_t p, smag_t q);
        smag_t r;
        if (p.neg == q.neg)
        begin
            r.neg = p.neg;
            r.mag = p.mag + q.mag;
        end
        else if (p.mag >= q.mag)
        begin
            r.neg = p.neg;
            r.mag = p.mag - q.mag;
        end
        else
        begin
            r.neg = q.neg;
            r.mag = q.mag - p.mag;
        end
        if (r.mag == 0)
            r.neg = 1'b0;
        return r;
    endfunction

    function automatic smag_t scaled_div(smag_t n, bit [63:0] d);
        bit [63:0] q;
        bit [63:0] rm;
        smag_t     r;
        q  = n.mag / d;
        rm = n.mag % d;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            if (q > (64'd1 << DATA_WIDTH))
                q = 64'd1 << DATA_WIDTH;
            q  = q << 1;
            rm = rm << 1;
            if (rm >= d)
            begin
                rm = rm - d;
                q[0] = 1'b1;
            end
        end
        r.mag = q;
        r.neg = (q != 0) && n.neg;
        return r;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] clamp(smag_t v, inout bit flag);
        bit [63:0] lim;
        bit [63:0] m;
        lim = v.neg ? (64'd1 << (DATA_WIDTH - 1)) : (64'd1 << (DATA_WIDTH - 1)) - 1;
        m   = v.mag;
        if (m > lim)
        begin
            m    = lim;
            flag = 1'b1;
        end
        return v.neg ? DATA_WIDTH'(-m) : DATA_WIDTH'(m);
    endfunction

    // Compute the expected result of one complex operation
    function automatic out_t complex_result(in_t x);
        longint    ar, ai, br, bi;
        smag_t     re, im;
        bit [63:0] den;
        bit        flag;
        out_t      r;
        ar   = x.a_real;
        ai   = x.a_imag;
        br   = x.b_real;
        bi   = x.b_imag;
        flag = 1'b0;
        case (x.operation)
            OP_ADD:
            begin
                re = to_smag(ar + br);
                im = to_smag(ai + bi);
            end
            OP_SUB:
            begin
                re = to_smag(ar - br);
                im = to_smag(ai - bi);
            end
            OP_MUL:
            begin
                re = to_smag(ar * br - ai * bi);
                im = to_smag(ai * br + ar * bi);
                re.mag = re.mag >> FRAC_BITS;
                im.mag = im.mag >> FRAC_BITS;
                if (re.mag == 0) re.neg = 1'b0;
                if (im.mag == 0) im.neg = 1'b0;
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    r.result_real = '0;
                    r.result_imag = '0;
                    r.status      = ST_DIV_ZERO;
                    return r;
                end
                re = scaled_div(to_smag(ar * br + ai * bi), den);
                im = scaled_div(to_smag(ai * br - ar * bi), den);
            end
        endcase
        r.result_real = clamp(re, flag);
        r.result_imag = clamp(im, flag);
        r.status      = flag ? ST_SAT : ST_OK;
        return r;
    endfunction

    // In-order store of expected results
    class result_board;
        out_t pending [$];

        function void note_operands(in_t x);
            pending.push_back(complex_result(x));
        endfunction

        task check_result(out_t got);
            out_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing pending");
                return;
            end
            want = pending.pop_front();
            if (got.result_real !== want.result_real)
                report_mismatch($sformatf("real got %h want %h",
                                          got.result_real, want.result_real));
            if (got.result_imag !== want.result_imag)
                report_mismatch($sformatf("imag got %h want %h",
                                          got.result_imag, want.result_imag));
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d",
                                          got.status, want.status));
        endtask
    endclass

    result_board board;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watch transfers in both directions and guard the run length
    always @(posedge clk)
    begin
        cycle++;
        if (rst_n && start && !busy)
            board.note_operands(operands);
        if (rst_n && result_valid)
            board.check_result(result);
        if (cycle > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("tb NOT OK");
            $finish;
        end
    end

    // Present one item and hold it until the transfer happens
    task automatic send_item(in_t x);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        operands <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_sent++;
        op_count[x.operation]++;
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return '0;
            3: return 16'(int'($urandom_range(1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_t random_item();
        in_t x;
        x.operation = op_t'($urandom_range(3));
        x.a_real    = pick_value();
        x.a_imag    = pick_value();
        x.b_real    = pick_value();
        x.b_imag    = pick_value();
        if (x.operation == OP_DIV && $urandom_range(19) == 0)
        begin
            x.b_real = '0;
            x.b_imag = '0;
        end
        return x;
    endfunction

    function automatic in_t make_item(op_t op, logic [15:0] ar, logic [15:0] ai,
                                      logic [15:0] br, logic [15:0] bi);
        in_t x;
        x.operation = op;
        x.a_real    = ar;
        x.a_imag    = ai;
        x.b_real    = br;
        x.b_imag    = bi;
        return x;
    endfunction

    initial
    begin
        board    = new();
        rst_n    = 1'b0;
        start    = 1'b0;
        operands = '0;
        idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: extremes, every operation, overflow, zero divisor
        for (int op = 0; op < 4; op++)
        begin
            send_item(make_item(op_t'(op), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
            send_item(make_item(op_t'(op), 16'h8000, 16'h8000, 16'h8000, 16'h8000));
            send_item(make_item(op_t'(op), 16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
            send_item(make_item(op_t'(op), 16'h0100, 16'hff00, 16'h0080, 16'h0001));
        end
        send_item(make_item(OP_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000));
        send_item(make_item(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000));
        send_item(make_item(OP_DIV, 16'h8000, 16'h0000, 16'hffff, 16'h0000));
        send_item(make_item(OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'hffff));

        // Random traffic in three idling phases
        for (int i = 0; i < N_RANDOM; i++)
        begin
            idle_pct = (i < N_RANDOM / 3) ? 35 : (i < 2 * N_RANDOM / 3) ? 46 : 0;
            send_item(random_item());
        end
        start <= 1'b0;

        // Drain the pipeline
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);

        $display("Sent %0d items: add %0d, sub %0d, mul %0d, div %0d.",
                 n_sent, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("Mismatches: %0d", n_errors);
        if (n_errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
